FILE: sv/byte_to_seven_bit_repacker_macros.svh
// Assertion macros shared by the repacker RTL.
// Both sample on clk and are disabled while arst_n is low.
`ifndef BYTE_TO_SEVEN_BIT_REPACKER_MACROS_SVH
`define BYTE_TO_SEVEN_BIT_REPACKER_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define RPK_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// When ante holds, cons must hold at the following edge.
`define RPK_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/rpk_pkg.sv
`timescale 1ns / 1ps

package rpk_pkg;

	localparam int unsigned ByteBits  = 8;
	localparam int unsigned ChunkBits = 7;
	localparam int unsigned HeldBits  = ChunkBits - 1;
	localparam int unsigned CountBits = 3;
	localparam int unsigned OccBits   = 2;

	// Most leftover bits that can be carried between words
	localparam logic [CountBits-1:0] HeldMax = CountBits'(HeldBits);

	// Output buffer fill levels
	localparam logic [OccBits-1:0] OccEmpty = 2'd0;
	localparam logic [OccBits-1:0] OccOne   = 2'd1;
	localparam logic [OccBits-1:0] OccTwo   = 2'd2;

	// Everything one input word produces
	typedef struct packed {
		logic [ChunkBits-1:0] chunk0;
		logic [ChunkBits-1:0] chunk1;
		logic                 two;
		logic                 last1;
		logic [HeldBits-1:0]  next_bits;
		logic [CountBits-1:0] next_count;
	} pack_res_t;

endpackage

FILE: sv/rpk_pack.sv
`timescale 1ns / 1ps

// Combinational slicer: held bits plus one byte into one or two chunks.
module rpk_pack (
	input  logic [rpk_pkg::HeldBits-1:0]  held_bits,
	input  logic [rpk_pkg::CountBits-1:0] held_count,
	input  logic [rpk_pkg::ByteBits-1:0]  data_byte,
	input  logic                          is_final,
	output rpk_pkg::pack_res_t            res
);

	localparam int unsigned AccBits = rpk_pkg::HeldBits + rpk_pkg::ByteBits;

	logic [rpk_pkg::CountBits-1:0] cnt;
	logic [rpk_pkg::CountBits-1:0] rem1;
	logic [rpk_pkg::HeldBits-1:0]  held_mask;
	logic [rpk_pkg::HeldBits-1:0]  rem_mask;
	logic [AccBits-1:0]            acc;
	logic [rpk_pkg::ChunkBits-1:0] tail;
	logic [rpk_pkg::ChunkBits-1:0] flush;

	always_comb begin
		// clamp count, only the valid held bits take part
		cnt       = (held_count > rpk_pkg::HeldMax) ? rpk_pkg::HeldMax : held_count;
		rem1      = cnt + rpk_pkg::CountBits'(1);
		held_mask = ~({rpk_pkg::HeldBits{1'b1}} << cnt);
		rem_mask  = ~({rpk_pkg::HeldBits{1'b1}} << rem1);
		acc       = {held_bits & held_mask, data_byte};

		// first chunk: top seven of the cnt+8 live bits
		res.chunk0 = rpk_pkg::ChunkBits'(acc >> rem1);

		// bits left after the first chunk, left-aligned for a flush
		tail  = {1'b0, acc[rpk_pkg::HeldBits-1:0] & rem_mask};
		flush = tail << (rpk_pkg::CountBits'(rpk_pkg::ChunkBits) - rem1);

		res.next_bits  = '0;
		res.next_count = '0;
		if (cnt == rpk_pkg::HeldMax) begin
			// exactly two full chunks, nothing held
			res.chunk1 = acc[rpk_pkg::ChunkBits-1:0];
			res.two    = 1'b1;
			res.last1  = is_final;
		end else if (is_final) begin
			res.chunk1 = flush;
			res.two    = 1'b1;
			res.last1  = 1'b1;
		end else begin
			res.chunk1     = '0;
			res.two        = 1'b0;
			res.last1      = 1'b0;
			res.next_bits  = acc[rpk_pkg::HeldBits-1:0] & rem_mask;
			res.next_count = rem1;
		end
	end

endmodule

FILE: sv/byte_to_seven_bit_repacker.sv
`timescale 1ns / 1ps
// A word's first chunk is offered in the cycle after the word is taken, and a word that
// yields two chunks blocks the next. Throughput, one-chunk words: one per cycle while
// out_ready is high; the two-entry buffer drains one chunk per cycle and is the limit.
// Reset (arst_n low, asynchronous): held bits and count clear, output buffer empties.
// A final word always returns the held state to its reset value.
`include "byte_to_seven_bit_repacker_macros.svh"

module byte_to_seven_bit_repacker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rpk_pkg::ByteBits-1:0]  data_byte,
	input  logic                          is_final,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rpk_pkg::ChunkBits-1:0] chunk,
	output logic                          chunk_last
);

	logic [rpk_pkg::HeldBits-1:0]  held_bits_q;
	logic [rpk_pkg::CountBits-1:0] held_count_q;
	logic [rpk_pkg::OccBits-1:0]   occ_q;
	logic [rpk_pkg::ChunkBits-1:0] chunk_q;
	logic                          last_q;
	logic [rpk_pkg::ChunkBits-1:0] pend_chunk_q;
	logic                          pend_last_q;
	rpk_pkg::pack_res_t            pk;
	logic                          push;
	logic                          pop;

	rpk_pack u_pack (
		.held_bits  (held_bits_q),
		.held_count (held_count_q),
		.data_byte  (data_byte),
		.is_final   (is_final),
		.res        (pk)
	);

	// handshakes: take a word when the buffer is or is becoming empty
	assign out_valid  = (occ_q != rpk_pkg::OccEmpty);
	assign pop        = out_valid && out_ready;
	assign in_ready   = (occ_q == rpk_pkg::OccEmpty) || ((occ_q == rpk_pkg::OccOne) && out_ready);
	assign push       = in_valid && in_ready;
	assign chunk      = chunk_q;
	assign chunk_last = last_q;

	// held state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_bits_q  <= '0;
			held_count_q <= '0;
		end else if (push) begin
			held_bits_q  <= pk.next_bits;
			held_count_q <= pk.next_count;
		end
	end

	// output buffer fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= rpk_pkg::OccEmpty;
		end else if (push) begin
			occ_q <= pk.two ? rpk_pkg::OccTwo : rpk_pkg::OccOne;
		end else if (pop) begin
			occ_q <= occ_q - rpk_pkg::OccBits'(1);
		end
	end

	// output buffer payload
	always_ff @(posedge clk) begin
		if (push) begin
			chunk_q      <= pk.chunk0;
			last_q       <= 1'b0;
			pend_chunk_q <= pk.chunk1;
			pend_last_q  <= pk.last1;
		end else if (pop) begin
			chunk_q <= pend_chunk_q;
			last_q  <= pend_last_q;
		end
	end

	`RPK_ASSERT_ALWAYS(a_occ_range, occ_q <= rpk_pkg::OccTwo, "output buffer fill out of range")
	`RPK_ASSERT_ALWAYS(a_held_range, held_count_q <= rpk_pkg::HeldMax, "held count above six")
	`RPK_ASSERT_NEXT(a_final_clears, push && is_final, held_count_q == '0, "final word left bits")
	`RPK_ASSERT_ALWAYS(a_last_is_second, !(chunk_last && occ_q == rpk_pkg::OccTwo), "last chunk early")
	`RPK_ASSERT_NEXT(a_pair_kept, occ_q == rpk_pkg::OccTwo, occ_q != rpk_pkg::OccEmpty, "chunk dropped")

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int unsigned StallLimit = 1000;

	typedef struct packed {
		logic [rpk_pkg::ChunkBits-1:0] chunk;
		logic                          last;
	} chunk_rec_t;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	logic [rpk_pkg::ByteBits-1:0]  data_byte;
	logic                          is_final;
	logic                          out_valid;
	logic                          out_ready;
	logic [rpk_pkg::ChunkBits-1:0] chunk;
	logic                          chunk_last;

	// Predictor copy of the leftover bits
	logic [rpk_pkg::HeldBits-1:0]  carry_bits;
	logic [rpk_pkg::CountBits-1:0] carry_count;

	chunk_rec_t  pending_chunks[$];
	bit          gaps_on;
	int unsigned error_count;
	int unsigned stall_cycles;

	byte_to_seven_bit_repacker u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.is_final   (is_final),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.chunk      (chunk),
		.chunk_last (chunk_last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Cut one byte into 7-bit chunks, MSB first, and queue what should come out
	function automatic void repack_byte(input logic [rpk_pkg::ByteBits-1:0] b, input logic fin);
		int unsigned cnt;
		int unsigned rem;
		int unsigned acc;
		chunk_rec_t  rec;
		cnt = (carry_count > rpk_pkg::HeldMax) ? rpk_pkg::HeldMax : carry_count;
		acc = int'(carry_bits) & ((1 << cnt) - 1);
		acc = (acc << rpk_pkg::ByteBits) | int'(b);
		rem = cnt + rpk_pkg::ByteBits - rpk_pkg::ChunkBits;
		rec.chunk = rpk_pkg::ChunkBits'(acc >> rem);
		rec.last = 1'b0;
		pending_chunks.push_back(rec);
		acc &= (1 << rem) - 1;
		if (rem >= rpk_pkg::ChunkBits) begin
			rem -= rpk_pkg::ChunkBits;
			rec.chunk = rpk_pkg::ChunkBits'(acc >> rem);
			rec.last = fin;
			pending_chunks.push_back(rec);
			acc &= (1 << rem) - 1;
		end else if (fin) begin
			// flush: leftover bits left-aligned, zero padded
			rec.chunk = rpk_pkg::ChunkBits'(acc << (rpk_pkg::ChunkBits - rem));
			rec.last = 1'b1;
			pending_chunks.push_back(rec);
		end
		if (fin) begin
			carry_bits = '0;
			carry_count = '0;
		end else begin
			carry_bits = rpk_pkg::HeldBits'(acc);
			carry_count = rpk_pkg::CountBits'(rem);
		end
	endfunction

	// Offer one word; entered and left at a falling edge
	task automatic send_word(input logic [rpk_pkg::ByteBits-1:0] b, input logic fin);
		while (gaps_on && $urandom_range(99) < 30) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		is_final <= fin;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		repack_byte(b, fin);
		@(negedge clk);
	endtask

	// Hold off the sender until every queued chunk has come out
	task automatic drain_chunks();
		in_valid <= 1'b0;
		while (pending_chunks.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Final byte at every held count; all-zero, all-one, mixed bytes before it
	task automatic test_directed();
		logic [rpk_pkg::ByteBits-1:0] pat [3];
		pat[0] = 8'hFF;
		pat[1] = 8'h00;
		pat[2] = 8'hA5;
		gaps_on = 1'b1;
		for (int k = 0; k <= rpk_pkg::HeldBits; k++) begin
			for (int i = 0; i < k; i++) send_word(pat[(k + i) % 3], 1'b0);
			send_word(pat[(k + 1) % 3] ^ 8'h5A, 1'b1);
		end
		drain_chunks();
	endtask

	// Well-formed buffers of random length and content
	task automatic test_random_buffers(input int unsigned n_words);
		int unsigned sent;
		int unsigned len;
		gaps_on = 1'b1;
		sent = 0;
		while (sent < n_words) begin
			len = ($urandom_range(7) == 0) ? $urandom_range(60, 20) : $urandom_range(16, 1);
			for (int unsigned i = 1; i <= len; i++)
				send_word(8'($urandom), i == len);
			sent += len;
		end
	endtask

	// Back-to-back words with both sides always ready
	task automatic test_steady_flow(input int unsigned n_words);
		gaps_on = 1'b0;
		repeat (n_words) send_word(8'($urandom), $urandom_range(11) == 0);
		send_word(8'($urandom), 1'b1);
		drain_chunks();
	endtask

	// Final flag set at random, often, with gaps back on
	task automatic test_mixed_finals(input int unsigned n_words);
		gaps_on = 1'b1;
		repeat (n_words) send_word(8'($urandom), $urandom_range(3) == 0);
		send_word(8'($urandom), 1'b1);
		drain_chunks();
	endtask

	// Receiver: random stalls while gaps are on
	initial begin
		forever begin
			@(negedge clk);
			out_ready <= gaps_on ? ($urandom_range(99) >= 30) : 1'b1;
		end
	end

	// Compare each chunk taken with the oldest expectation
	always @(posedge clk) begin : check_chunks
		chunk_rec_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_chunks.size() == 0) begin
				error_count++;
				$display("%0t: unexpected chunk: expected none, actual chunk=%h last=%b",
					$time, chunk, chunk_last);
			end else begin
				want = pending_chunks.pop_front();
				if (chunk !== want.chunk) begin
					error_count++;
					$display("%0t: chunk mismatch: expected %h, actual %h",
						$time, want.chunk, chunk);
				end
				if (chunk_last !== want.last) begin
					error_count++;
					$display("%0t: chunk_last mismatch: expected %b, actual %b",
						$time, want.last, chunk_last);
				end
			end
		end
	end

	// Watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= StallLimit) begin
			$display("byte_to_seven_bit_repacker test failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		is_final = 1'b0;
		out_ready = 1'b0;
		gaps_on = 1'b0;
		error_count = 0;
		stall_cycles = 0;
		carry_bits = '0;
		carry_count = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random_buffers(600);
		test_steady_flow(400);
		test_mixed_finals(300);

		drain_chunks();
		repeat (8) @(posedge clk);
		if (error_count == 0 && pending_chunks.size() == 0) begin
			$display("byte_to_seven_bit_repacker test passed");
		end else begin
			$display("byte_to_seven_bit_repacker test failed");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+sv
sv/rpk_pkg.sv
sv/rpk_pack.sv
sv/byte_to_seven_bit_repacker.sv
test/testbench.sv
